/* rtl/core/bmtp_pkg.sv */
package bmtp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_BLOCK  = 64;

	localparam int X_W     = $clog2(MAX_WIDTH);
	localparam int Y_W     = $clog2(MAX_HEIGHT);
	localparam int BLK_W   = $clog2(MAX_BLOCK);
	localparam int SUM_W   = 20;
	localparam int TOTAL_W = SUM_W + BLK_W;
	localparam int PIX_W   = 8;
	localparam int OUT_W   = 12;

	localparam int CFG_DIM_W  = 11;
	localparam int CFG_BLK_W  = 7;
	localparam int CFG_THR_W  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam int COUNT_W = 2 * CFG_BLK_W;
	localparam int PROD_W  = CFG_THR_W + COUNT_W;

	localparam logic [CFG_DIM_W-1:0] DIM_RESET       = CFG_DIM_W'(1024);
	localparam logic [CFG_BLK_W-1:0] BLK_RESET       = CFG_BLK_W'(1);
	localparam logic [CFG_THR_W-1:0] THRESHOLD_RESET = CFG_THR_W'(127);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_BLOCK_WIDTH  = 3'd2,
		REG_BLOCK_HEIGHT = 3'd3,
		REG_THRESHOLD    = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SWEEP,
		ST_DRAIN,
		ST_COMPARE
	} state_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic sweep_read;
		logic result_load;
	} dp_cmd_t;

	typedef struct packed {
		logic block_done;
		logic sweep_last;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/core/block_mean_threshold_points_core.sv */
// Block mean threshold: red pixels arrive in raster order and the image is
// tiled into blocks of the configured size, clipped at the right and bottom
// edges. Each block's sum is held per column in a 1024 x 20 bit RAM. When a
// block's last pixel arrives and its sum exceeds threshold * pixel count, the
// block centre (2*origin + block size, half-pixel units) is sent out. A pixel
// has its column sum read from the RAM and then written back updated. A pixel
// that closes a block then has the single RAM read port walk the block's
// columns one per cycle, and waits for the result register to be taken.
// tuser marks the first pixel of a frame; the position also wraps by itself
// after the last pixel of an image.
// Configuration is taken at any time but must only change while idle.
module block_mean_threshold_points_core
	import bmtp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] pixel_red
	input  logic [0:0]            s_axis_tuser,  // [0] frame_start
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata   // [11:0] center_x2, [23:12] center_y2
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	bmtp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.status       (status),
		.cmd          (cmd)
	);

	bmtp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.cmd          (cmd),
		.status       (status),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

/* rtl/core/bmtp_ram.sv */
module bmtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/bmtp_datapath.sv */
module bmtp_datapath
	import bmtp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [7:0]            s_axis_tdata,
	input  logic [0:0]            s_axis_tuser,
	input  dp_cmd_t               cmd,
	output dp_status_t            status,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata
);

	logic [CFG_DIM_W-1:0] image_width_q, image_height_q;
	logic [CFG_BLK_W-1:0] block_width_q, block_height_q;
	logic [CFG_THR_W-1:0] threshold_q;

	logic [CFG_DIM_W-1:0] w, h;
	logic [CFG_BLK_W-1:0] bw, bh;

	logic [X_W-1:0]   pixel_x_q, px, px_next;
	logic [Y_W-1:0]   pixel_y_q, py, py_next;
	logic [BLK_W-1:0] col_in_block_q, cib, cib_next;
	logic [BLK_W-1:0] row_in_block_q, rib, rib_next;
	logic             row_end, last_row, col_end, brow_end, bw_wrap, bh_wrap;

	logic [PIX_W-1:0] red_s1;
	logic             first_row_s1;
	logic             done_s1;
	logic [X_W-1:0]   x_s1, x0_s1;
	logic [Y_W-1:0]   y0_s1;
	logic [BLK_W-1:0] cib_s1, rib_s1;

	logic [COUNT_W-1:0] pixels_q;
	logic [PROD_W-1:0]  prod_q;
	logic [TOTAL_W-1:0] total_q;
	logic [X_W-1:0]     col_q;
	logic               acc_valid_q;

	logic             ram_we;
	logic [X_W-1:0]   ram_raddr;
	logic [SUM_W-1:0] ram_wdata, ram_rdata;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_x2_q, out_y2_q;
	logic             pass;

	bmtp_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_WIDTH)
	) u_column_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(x_s1),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_RESET;
			image_height_q <= DIM_RESET;
			block_width_q  <= BLK_RESET;
			block_height_q <= BLK_RESET;
			threshold_q    <= THRESHOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[CFG_DIM_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[CFG_DIM_W-1:0];
				REG_BLOCK_WIDTH:  block_width_q  <= cfg_data[CFG_BLK_W-1:0];
				REG_BLOCK_HEIGHT: block_height_q <= cfg_data[CFG_BLK_W-1:0];
				REG_THRESHOLD:    threshold_q    <= cfg_data[CFG_THR_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the registers to their legal ranges
	always_comb begin
		w  = image_width_q;
		h  = image_height_q;
		bw = block_width_q;
		bh = block_height_q;
		if (image_width_q == '0) w = CFG_DIM_W'(1);
		else if (image_width_q > CFG_DIM_W'(MAX_WIDTH)) w = CFG_DIM_W'(MAX_WIDTH);
		if (image_height_q == '0) h = CFG_DIM_W'(1);
		else if (image_height_q > CFG_DIM_W'(MAX_HEIGHT)) h = CFG_DIM_W'(MAX_HEIGHT);
		if (block_width_q == '0) bw = CFG_BLK_W'(1);
		else if (block_width_q > CFG_BLK_W'(MAX_BLOCK)) bw = CFG_BLK_W'(MAX_BLOCK);
		if (block_height_q == '0) bh = CFG_BLK_W'(1);
		else if (block_height_q > CFG_BLK_W'(MAX_BLOCK)) bh = CFG_BLK_W'(MAX_BLOCK);
	end

	// position of the incoming pixel and where the scan goes next
	always_comb begin
		px  = s_axis_tuser[0] ? '0 : pixel_x_q;
		py  = s_axis_tuser[0] ? '0 : pixel_y_q;
		cib = s_axis_tuser[0] ? '0 : col_in_block_q;
		rib = s_axis_tuser[0] ? '0 : row_in_block_q;

		row_end  = (CFG_DIM_W'(px) + CFG_DIM_W'(1)) >= w;
		last_row = (CFG_DIM_W'(py) + CFG_DIM_W'(1)) >= h;
		bw_wrap  = (CFG_BLK_W'(cib) + CFG_BLK_W'(1)) >= bw;
		bh_wrap  = (CFG_BLK_W'(rib) + CFG_BLK_W'(1)) >= bh;
		col_end  = row_end | bw_wrap;
		brow_end = last_row | bh_wrap;

		px_next  = px + X_W'(1);
		py_next  = py;
		cib_next = bw_wrap ? '0 : cib + BLK_W'(1);
		rib_next = rib;
		if (row_end) begin
			px_next  = '0;
			cib_next = '0;
			if (last_row) begin
				py_next  = '0;
				rib_next = '0;
			end else begin
				py_next  = py + Y_W'(1);
				rib_next = bh_wrap ? '0 : rib + BLK_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x_q      <= '0;
			pixel_y_q      <= '0;
			col_in_block_q <= '0;
			row_in_block_q <= '0;
			done_s1        <= 1'b0;
		end else if (cmd.accept) begin
			pixel_x_q      <= px_next;
			pixel_y_q      <= py_next;
			col_in_block_q <= cib_next;
			row_in_block_q <= rib_next;
			done_s1        <= col_end & brow_end;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			red_s1       <= s_axis_tdata[PIX_W-1:0];
			first_row_s1 <= (rib == '0);
			x_s1         <= px;
			x0_s1        <= px - X_W'(cib);
			y0_s1        <= py - Y_W'(rib);
			cib_s1       <= cib;
			rib_s1       <= rib;
		end
	end

	// read-modify-write of the column sum
	assign ram_we    = cmd.update;
	assign ram_wdata = first_row_s1 ? SUM_W'(red_s1) : ram_rdata + SUM_W'(red_s1);
	assign ram_raddr = cmd.accept ? px : col_q;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			pixels_q <= (COUNT_W'(cib_s1) + COUNT_W'(1)) * (COUNT_W'(rib_s1) + COUNT_W'(1));
		end
		prod_q <= PROD_W'(threshold_q) * PROD_W'(pixels_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_q <= 1'b0;
		end else begin
			acc_valid_q <= cmd.sweep_read;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			col_q   <= x0_s1;
			total_q <= '0;
		end else begin
			if (cmd.sweep_read) col_q <= col_q + X_W'(1);
			if (acc_valid_q) total_q <= total_q + TOTAL_W'(ram_rdata);
		end
	end

	assign pass = total_q > TOTAL_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= pass;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			out_x2_q <= OUT_W'({x0_s1, 1'b0}) + OUT_W'(bw);
			out_y2_q <= OUT_W'({y0_s1, 1'b0}) + OUT_W'(bh);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_y2_q, out_x2_q};

	assign status.block_done = done_s1;
	assign status.sweep_last = (col_q == x_s1);
	assign status.out_free   = !out_valid_q || m_axis_tready;

endmodule

/* rtl/core/bmtp_ctrl.sv */
module bmtp_ctrl
	import bmtp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_next = status.block_done ? ST_SWEEP : ST_IDLE;
			end
			ST_SWEEP: begin
				if (status.sweep_last) state_next = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_next = ST_COMPARE;
			end
			ST_COMPARE: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready   = 1'b0;
		cmd             = '0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.accept    = s_axis_tvalid;
			end
			ST_UPDATE:  cmd.update      = 1'b1;
			ST_SWEEP:   cmd.sweep_read  = 1'b1;
			ST_DRAIN:   ;
			ST_COMPARE: cmd.result_load = status.out_free;
			default: ;
		endcase
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
	import bmtp_pkg::*;

	localparam int RANDOM_ITEMS = 800;
	localparam int PHASE_PIXELS = 300;
	localparam int DRAIN_CYCLES = 4 + MAX_BLOCK + 16;
	localparam int MAX_REPORTS  = 30;

	typedef struct packed {
		logic [OUT_W-1:0] y2;
		logic [OUT_W-1:0] x2;
	} centre_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [23:0]           m_axis_tdata;

	// mirror of the block's registers and raster position
	logic [CFG_DIM_W-1:0] img_w_reg = DIM_RESET;
	logic [CFG_DIM_W-1:0] img_h_reg = DIM_RESET;
	logic [CFG_BLK_W-1:0] blk_w_reg = BLK_RESET;
	logic [CFG_BLK_W-1:0] blk_h_reg = BLK_RESET;
	logic [CFG_THR_W-1:0] thr_reg   = THRESHOLD_RESET;
	logic [SUM_W-1:0]     col_sum [MAX_WIDTH];
	logic [X_W-1:0]       pos_x      = '0;
	logic [Y_W-1:0]       pos_y      = '0;
	logic [BLK_W-1:0]     col_in_blk = '0;
	logic [BLK_W-1:0]     row_in_blk = '0;

	centre_t expected_centres[$];
	int      mismatch_count    = 0;
	bit      sender_idling     = 1'b0;
	bit      receiver_idling   = 1'b0;
	int      ready_hold_cycles = 0;

	block_mean_threshold_points_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS) begin
			$display("%0t mismatch: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	function automatic int clamp_to(input int v, input int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// mostly close to the threshold so that block means fall on both sides
	function automatic logic [PIX_W-1:0] pick_red(input int level);
		int v;
		if ($urandom_range(99) < 30) return PIX_W'($urandom_range(255));
		v = level + int'($urandom_range(24)) - 12;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return PIX_W'(v);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dim(input int usual);
		int r;
		r = $urandom_range(99);
		if (r < 3) return '0;
		if (r < 6) return CFG_DATA_W'($urandom_range(MAX_WIDTH + 1, (1 << CFG_DATA_W) - 1));
		if (r < 85) return CFG_DATA_W'($urandom_range(1, usual));
		return CFG_DATA_W'($urandom_range(1, 4 * usual));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_block();
		int r;
		r = $urandom_range(99);
		if (r < 4) return '0;
		if (r < 10) return CFG_DATA_W'($urandom_range(MAX_BLOCK + 1, (1 << CFG_DATA_W) - 1));
		if (r < 55) return CFG_DATA_W'($urandom_range(1, 8));
		return CFG_DATA_W'($urandom_range(1, MAX_BLOCK));
	endfunction

	// accumulate one pixel into its column and queue the centre of a bright block
	task automatic predict_block_centre(input logic [PIX_W-1:0] red, input logic first);
		int      w, h, bw, bh, x, total, pixels;
		bit      row_end, last_row, col_end, band_end;
		centre_t centre;
		w  = clamp_to(int'(img_w_reg), MAX_WIDTH);
		h  = clamp_to(int'(img_h_reg), MAX_HEIGHT);
		bw = clamp_to(int'(blk_w_reg), MAX_BLOCK);
		bh = clamp_to(int'(blk_h_reg), MAX_BLOCK);
		if (first) begin
			pos_x      = '0;
			pos_y      = '0;
			col_in_blk = '0;
			row_in_blk = '0;
		end
		x = int'(pos_x);
		if (row_in_blk == '0) begin
			col_sum[x] = SUM_W'(red);
		end else begin
			col_sum[x] = col_sum[x] + SUM_W'(red);
		end
		row_end  = int'(pos_x) + 1 >= w;
		last_row = int'(pos_y) + 1 >= h;
		col_end  = row_end || int'(col_in_blk) + 1 >= bw;
		band_end = last_row || int'(row_in_blk) + 1 >= bh;
		if (col_end && band_end) begin
			total  = 0;
			pixels = (int'(col_in_blk) + 1) * (int'(row_in_blk) + 1);
			for (int c = x - int'(col_in_blk); c <= x; c++) total += int'(col_sum[c]);
			if (total > int'(thr_reg) * pixels) begin
				centre.x2 = OUT_W'(2 * (x - int'(col_in_blk)) + bw);
				centre.y2 = OUT_W'(2 * (int'(pos_y) - int'(row_in_blk)) + bh);
				expected_centres.insert(expected_centres.size(), centre);
			end
		end
		if (row_end) begin
			pos_x      = '0;
			col_in_blk = '0;
			if (last_row) begin
				pos_y      = '0;
				row_in_blk = '0;
			end else begin
				pos_y      = pos_y + 1'b1;
				row_in_blk = (int'(row_in_blk) + 1 >= bh) ? '0 : row_in_blk + 1'b1;
			end
		end else begin
			pos_x      = pos_x + 1'b1;
			col_in_blk = (int'(col_in_blk) + 1 >= bw) ? '0 : col_in_blk + 1'b1;
		end
	endtask

	// entered and left at a falling edge
	task automatic send_pixel(input logic [PIX_W-1:0] red, input logic first);
		int gap;
		if (sender_idling && $urandom_range(99) < 25) begin
			gap = pick_gap();
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = red;
		s_axis_tuser  = first;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		predict_block_centre(red, first);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_IMAGE_WIDTH:  img_w_reg = data;
			REG_IMAGE_HEIGHT: img_h_reg = data;
			REG_BLOCK_WIDTH:  blk_w_reg = data[CFG_BLK_W-1:0];
			REG_BLOCK_HEIGHT: blk_h_reg = data[CFG_BLK_W-1:0];
			REG_THRESHOLD:    thr_reg   = data[CFG_THR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input logic [CFG_DATA_W-1:0] bw, input logic [CFG_DATA_W-1:0] bh,
			input logic [CFG_DATA_W-1:0] thr);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_BLOCK_WIDTH, bw);
		write_reg(REG_BLOCK_HEIGHT, bh);
		write_reg(REG_THRESHOLD, thr);
	endtask

	task automatic wait_results();
		while (expected_centres.size() != 0) @(negedge clk);
	endtask

	// a pixel that brings no centre may still be in flight; let it settle
	task automatic wait_idle();
		wait_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// 1x1 blocks at the reset threshold: one centre per pixel brighter than it
	task automatic test_reset_defaults();
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		send_pixel(8'd200, 1'b1);
		send_pixel(8'd127, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd255, 1'b1);
	endtask

	task automatic test_register_limits();
		wait_idle();
		receiver_idling = 1'b1;
		configure('0, '0, '0, '0, '0);
		for (int i = int'(REG_THRESHOLD) + 1; i < (1 << CFG_IDX_W); i++) begin
			write_reg(CFG_IDX_W'(i), '1);
		end
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd255, 1'b1);
		wait_idle();
		// block width above the maximum, high bits set on the block size and threshold writes
		configure(CFG_DATA_W'(3), CFG_DATA_W'(1), '1, CFG_DATA_W'(11'h7C0), CFG_DATA_W'(11'h7FE));
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd254, 1'b0);
	endtask

	// right and bottom blocks clipped, then wrap into the next image
	task automatic test_clipped_blocks();
		wait_idle();
		sender_idling = 1'b1;
		configure(CFG_DATA_W'(3), CFG_DATA_W'(3), CFG_DATA_W'(2), CFG_DATA_W'(2), CFG_DATA_W'(50));
		for (int i = 0; i < 10; i++) send_pixel(pick_red(50), i == 0);
	endtask

	// shrink the image and change block sizes with the position mid-image
	task automatic test_mid_image_change();
		wait_idle();
		configure(CFG_DATA_W'(8), CFG_DATA_W'(8), CFG_DATA_W'(4), CFG_DATA_W'(4), CFG_DATA_W'(60));
		for (int i = 0; i < 29; i++) send_pixel(pick_red(60), i == 0);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(6));
		write_reg(REG_BLOCK_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_BLOCK_HEIGHT, CFG_DATA_W'(2));
		write_reg(REG_THRESHOLD, CFG_DATA_W'(90));
		for (int i = 0; i < 40; i++) send_pixel(pick_red(90), 1'b0);
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
		for (int i = 0; i < 14; i++) send_pixel(pick_red(90), 1'b0);
	endtask

	// hold the output long enough for the block to stall its input
	task automatic test_output_stall();
		wait_idle();
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		configure(CFG_DATA_W'(16), CFG_DATA_W'(16), CFG_DATA_W'(1), CFG_DATA_W'(1), '0);
		ready_hold_cycles = 300;
		for (int i = 0; i < 150; i++) send_pixel(PIX_W'($urandom_range(1, 255)), i == 0);
		wait_results();
	endtask

	task automatic test_random_images();
		int                    sent, w, h, frame_len, pixels, level;
		logic [CFG_DATA_W-1:0] thr_raw;
		logic                  first;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			sender_idling   = $urandom_range(99) < 75;
			receiver_idling = $urandom_range(99) < 75;
			thr_raw = CFG_DATA_W'($urandom);
			level   = int'(thr_raw[CFG_THR_W-1:0]);
			configure(pick_dim(24), pick_dim(8), pick_block(), pick_block(), thr_raw);
			if ($urandom_range(9) == 0) begin
				write_reg(CFG_IDX_W'($urandom_range(int'(REG_THRESHOLD) + 1, (1 << CFG_IDX_W) - 1)),
					CFG_DATA_W'($urandom));
			end
			w         = clamp_to(int'(img_w_reg), MAX_WIDTH);
			h         = clamp_to(int'(img_h_reg), MAX_HEIGHT);
			frame_len = w * h;
			pixels    = frame_len * $urandom_range(1, 3);
			if (pixels > PHASE_PIXELS) pixels = PHASE_PIXELS;
			for (int i = 0; i < pixels; i++) begin
				// restart at image boundaries now and then, and rarely mid-image
				first = i == 0 || (i % frame_len == 0 && $urandom_range(1) == 1) ||
					$urandom_range(99) < 2;
				send_pixel(pick_red(level), first);
				if (i == pixels / 2 && $urandom_range(9) == 0) wait_results();
			end
			sent += pixels;
		end
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left    = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold_cycles > 0) begin
				m_axis_tready = 1'b0;
				ready_hold_cycles--;
			end else if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = 1'b1;
				if (receiver_idling && $urandom_range(99) < 20) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : centre_check
		centre_t got, want;
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			got = centre_t'(m_axis_tdata);
			if (expected_centres.size() == 0) begin
				report_mismatch($sformatf("unexpected centre x2=%0d y2=%0d", got.x2, got.y2));
			end else begin
				want = expected_centres.pop_front();
				if (got.x2 !== want.x2) begin
					report_mismatch($sformatf("center_x2 %0d, want %0d", got.x2, want.x2));
				end
				if (got.y2 !== want.y2) begin
					report_mismatch($sformatf("center_y2 %0d, want %0d", got.y2, want.y2));
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d centres outstanding", expected_centres.size());
		$display("FAIL block_mean_threshold_points_core");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_register_limits();
		test_clipped_blocks();
		test_mid_image_change();
		test_output_stall();
		test_random_images();
		wait_idle();
		if (mismatch_count == 0) begin
			$display("PASS block_mean_threshold_points_core");
		end else begin
			$display("FAIL block_mean_threshold_points_core");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/bmtp_pkg.sv
rtl/core/bmtp_ram.sv
rtl/core/bmtp_datapath.sv
rtl/core/bmtp_ctrl.sv
rtl/core/block_mean_threshold_points_core.sv
test/tb.sv
